FILE: src/osa_pkg.sv
package osa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int AVG_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int OS_W       = 8;
    localparam int SPOT_W     = 16;
    localparam int PLANE_W    = 8;
    localparam int FRAME_W    = 16;
    localparam int CH_CFG_W   = 4;
    localparam int CH_OUT_W   = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT    = 2'd0,
        REG_OVERSAMPLE_COUNT = 2'd1,
        REG_SPOTS_PER_PLANE  = 2'd2,
        REG_PLANE_COUNT      = 2'd3
    } osa_cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } osa_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } osa_cmd_t;

    typedef struct packed {
        logic last_os;
        logic out_free;
    } osa_status_t;

endpackage

FILE: src/osa_ctrl.sv
module osa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  osa_pkg::osa_status_t status,
    output osa_pkg::osa_cmd_t    cmd
);
    import osa_pkg::*;

    osa_state_t        state_reg;
    osa_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.last_os)
                    begin
                        state_next = ST_DIVIDE;
                        step_next  = '0;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // wait for the output register to empty
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/osa_datapath.sv
module osa_datapath #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [osa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [osa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [osa_pkg::SAMPLE_W-1:0]        sample,
    input  osa_pkg::osa_cmd_t                   cmd,
    output osa_pkg::osa_status_t                status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [osa_pkg::AVG_W-1:0]           average,
    output logic [osa_pkg::CH_OUT_W-1:0]        channel_index,
    output logic [osa_pkg::SPOT_W-1:0]          spot_index,
    output logic [osa_pkg::PLANE_W-1:0]         plane_index,
    output logic [osa_pkg::FRAME_W-1:0]         frame_index,
    output logic                                frame_done
);
    import osa_pkg::*;

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int MW = (CW + 1 > CH_CFG_W) ? CW + 1 : CH_CFG_W;

    // configuration
    logic [CH_CFG_W-1:0] ch_cfg_reg;
    logic [OS_W-1:0]     os_cfg_reg;
    logic [SPOT_W-1:0]   sp_cfg_reg;
    logic [PLANE_W-1:0]  pl_cfg_reg;

    // position counters and running sums
    logic [CW-1:0]       ch_pos_reg;
    logic [OS_W-1:0]     os_pos_reg;
    logic [SPOT_W-1:0]   sp_pos_reg;
    logic [PLANE_W-1:0]  pl_pos_reg;
    logic [FRAME_W-1:0]  fr_pos_reg;
    logic [SUM_W-1:0]    sums_reg [MAX_CHANNELS];

    // result tag captured at accept
    logic [CW-1:0]       tag_ch_reg;
    logic [SPOT_W-1:0]   tag_sp_reg;
    logic [PLANE_W-1:0]  tag_pl_reg;
    logic [FRAME_W-1:0]  tag_fr_reg;
    logic                tag_done_reg;

    // divider
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [OS_W-1:0]       rem_reg;
    logic [OS_W-1:0]       divisor_reg;
    logic [OS_W:0]         rem_shift;
    logic [OS_W:0]         rem_diff;
    logic                  rem_ge;

    // output register
    logic                out_valid_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [CW-1:0]       out_ch_reg;
    logic [SPOT_W-1:0]   out_sp_reg;
    logic [PLANE_W-1:0]  out_pl_reg;
    logic [FRAME_W-1:0]  out_fr_reg;
    logic                out_done_reg;

    logic [MW-1:0]       eff_ch;
    logic [OS_W-1:0]     eff_os;
    logic [SPOT_W-1:0]   eff_sp;
    logic [PLANE_W-1:0]  eff_pl;
    logic                last_ch;
    logic                last_os;
    logic                last_sp;
    logic                last_pl;
    logic [SUM_W-1:0]    sum_new;

    // a zero count acts as one; too many channels clamp to the maximum
    always_comb
    begin
        if (ch_cfg_reg == '0)
        begin
            eff_ch = MW'(1);
        end
        else if (MW'(ch_cfg_reg) > MW'(MAX_CHANNELS))
        begin
            eff_ch = MW'(MAX_CHANNELS);
        end
        else
        begin
            eff_ch = MW'(ch_cfg_reg);
        end
    end

    assign eff_os  = (os_cfg_reg == '0) ? OS_W'(1) : os_cfg_reg;
    assign eff_sp  = (sp_cfg_reg == '0) ? SPOT_W'(1) : sp_cfg_reg;
    assign eff_pl  = (pl_cfg_reg == '0) ? PLANE_W'(1) : pl_cfg_reg;

    assign last_ch = MW'(ch_pos_reg) >= (eff_ch - MW'(1));
    assign last_os = os_pos_reg >= (eff_os - OS_W'(1));
    assign last_sp = sp_pos_reg >= (eff_sp - SPOT_W'(1));
    assign last_pl = pl_pos_reg >= (eff_pl - PLANE_W'(1));

    // first oversample of a spot loads the sum, later ones add to it
    assign sum_new = (os_pos_reg == '0) ? SUM_W'(sample)
                                        : sums_reg[ch_pos_reg] + SUM_W'(sample);

    assign status.last_os  = last_os;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cfg_reg <= CH_CFG_W'(1);
            os_cfg_reg <= OS_W'(1);
            sp_cfg_reg <= SPOT_W'(1);
            pl_cfg_reg <= PLANE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (osa_cfg_reg_t'(cfg_index))
                REG_CHANNEL_COUNT:    ch_cfg_reg <= cfg_data[CH_CFG_W-1:0];
                REG_OVERSAMPLE_COUNT: os_cfg_reg <= cfg_data[OS_W-1:0];
                REG_SPOTS_PER_PLANE:  sp_cfg_reg <= cfg_data[SPOT_W-1:0];
                REG_PLANE_COUNT:      pl_cfg_reg <= cfg_data[PLANE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_pos_reg <= '0;
            os_pos_reg <= '0;
            sp_pos_reg <= '0;
            pl_pos_reg <= '0;
            fr_pos_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            sums_reg[ch_pos_reg] <= last_os ? '0 : sum_new;
            if (!last_ch)
            begin
                ch_pos_reg <= ch_pos_reg + 1'b1;
            end
            else
            begin
                ch_pos_reg <= '0;
                if (!last_os)
                begin
                    os_pos_reg <= os_pos_reg + 1'b1;
                end
                else
                begin
                    os_pos_reg <= '0;
                    if (!last_sp)
                    begin
                        sp_pos_reg <= sp_pos_reg + 1'b1;
                    end
                    else
                    begin
                        sp_pos_reg <= '0;
                        if (!last_pl)
                        begin
                            pl_pos_reg <= pl_pos_reg + 1'b1;
                        end
                        else
                        begin
                            pl_pos_reg <= '0;
                            fr_pos_reg <= fr_pos_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // restoring division, one quotient bit a step
    assign rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_os)
        begin
            quot_reg     <= {sum_new, FRAC_W'(0)};
            rem_reg      <= '0;
            divisor_reg  <= eff_os;
            tag_ch_reg   <= ch_pos_reg;
            tag_sp_reg   <= sp_pos_reg;
            tag_pl_reg   <= pl_pos_reg;
            tag_fr_reg   <= fr_pos_reg;
            tag_done_reg <= last_ch && last_sp && last_pl;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[OS_W-1:0] : rem_shift[OS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            avg_reg      <= quot_reg[AVG_W-1:0];
            out_ch_reg   <= tag_ch_reg;
            out_sp_reg   <= tag_sp_reg;
            out_pl_reg   <= tag_pl_reg;
            out_fr_reg   <= tag_fr_reg;
            out_done_reg <= tag_done_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = avg_reg;
    assign channel_index = CH_OUT_W'(out_ch_reg);
    assign spot_index    = out_sp_reg;
    assign plane_index   = out_pl_reg;
    assign frame_index   = out_fr_reg;
    assign frame_done    = out_done_reg;

endmodule

FILE: src/oversampled_spot_averager.sv
// Oversampled spot averager. Raw 16-bit samples come in interleaved with the
// channel varying fastest, then oversample, spot, plane and frame. The block
// keeps one running sum per channel and, on the last oversample of a channel
// for a spot, gives one item: the average as unsigned 16.8 fixed point
// (sum * 256 / oversample_count, fraction truncated) with its channel, spot,
// plane and frame position, and frame_done on the last average of a frame.
// Timing: a sample that closes no average is accepted on arrival while the
// block is idle, and the next may follow straight after. A sample that
// closes an average occupies the block while it is accepted, divided
// by the bit-serial divider (one quotient bit per cycle, 32-bit dividend)
// and loaded into a free output register, which holds a finished item while
// the next samples are taken, so a stalled output only blocks input once a
// second average is ready. Write configuration while the block is idle; a
// zero count acts as one and a channel count above MAX_CHANNELS is clamped.
module oversampled_spot_averager #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [osa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [osa_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [osa_pkg::SAMPLE_W-1:0]     sample,
    // result output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [osa_pkg::AVG_W-1:0]        average,
    output logic [osa_pkg::CH_OUT_W-1:0]     channel_index,
    output logic [osa_pkg::SPOT_W-1:0]       spot_index,
    output logic [osa_pkg::PLANE_W-1:0]      plane_index,
    output logic [osa_pkg::FRAME_W-1:0]      frame_index,
    output logic                             frame_done
);
    import osa_pkg::*;

    osa_cmd_t    cmd;
    osa_status_t status;

    // sequence accept, divide and hand-over
    osa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, sums, divider and output register
    osa_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .average       (average),
        .channel_index (channel_index),
        .spot_index    (spot_index),
        .plane_index   (plane_index),
        .frame_index   (frame_index),
        .frame_done    (frame_done)
    );

endmodule

FILE: dv/tb_oversampled_spot_averager.sv
`timescale 1ns / 100ps

module tb_oversampled_spot_averager;

    import osa_pkg::*;

    localparam int MAX_CH = 8;

    // One finished spot average, as the block presents it on its output ports
    typedef struct packed {
        logic [AVG_W-1:0]    average;
        logic [CH_OUT_W-1:0] channel;
        logic [SPOT_W-1:0]   spot;
        logic [PLANE_W-1:0]  plane;
        logic [FRAME_W-1:0]  frame;
        logic                done;
    } spot_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [AVG_W-1:0]      average;
    logic [CH_OUT_W-1:0]   channel_index;
    logic [SPOT_W-1:0]     spot_index;
    logic [PLANE_W-1:0]    plane_index;
    logic [FRAME_W-1:0]    frame_index;
    logic                  frame_done;

    oversampled_spot_averager #(
        .MAX_CHANNELS (MAX_CH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average),
        .channel_index (channel_index),
        .spot_index    (spot_index),
        .plane_index   (plane_index),
        .frame_index   (frame_index),
        .frame_done    (frame_done)
    );

    always #4 clk = ~clk;

    // Samples waiting to be driven, and averages predicted but not yet seen
    logic [SAMPLE_W-1:0] samples_to_send[$];
    spot_result_t        averages_due[$];
    spot_result_t        oldest_due;
    int                  samples_queued = 0;
    int                  samples_taken = 0;
    int                  mismatches = 0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    bit                  calm = 1'b0;

    // Mirror of the registers as the block sees them after masking
    logic [CH_CFG_W-1:0] cfg_channels = 4'd1;
    logic [OS_W-1:0]     cfg_oversample = 8'd1;
    logic [SPOT_W-1:0]   cfg_spots = 16'd1;
    logic [PLANE_W-1:0]  cfg_planes = 8'd1;

    // Predictor state: per-channel running sums and the acquisition position
    logic [SUM_W-1:0]    acc_sum[MAX_CH];
    logic [2:0]          pos_ch = '0;
    logic [OS_W-1:0]     pos_os = '0;
    logic [SPOT_W-1:0]   pos_spot = '0;
    logic [PLANE_W-1:0]  pos_plane = '0;
    logic [FRAME_W-1:0]  pos_frame = '0;

    initial
    begin
        for (int i = 0; i < MAX_CH; i++)
            acc_sum[i] = '0;
    end

    // Fold one accepted sample into the running sums and advance the
    // acquisition position; queue an average when the sample closes one.
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
        int                  nch;
        int                  nos;
        int                  nsp;
        int                  npl;
        int                  ch;
        bit                  last_ch;
        bit                  last_os;
        bit                  last_sp;
        bit                  last_pl;
        logic [SUM_W-1:0]    sum;
        logic [DIVIDEND_W-1:0] quotient;
        spot_result_t        res;
        // a zero count acts as one; too many channels clamp to the maximum
        nch = (cfg_channels == 0) ? 1 : int'(cfg_channels);
        if (nch > MAX_CH)
            nch = MAX_CH;
        nos = (cfg_oversample == 0) ? 1 : int'(cfg_oversample);
        nsp = (cfg_spots == 0) ? 1 : int'(cfg_spots);
        npl = (cfg_planes == 0) ? 1 : int'(cfg_planes);
        // a position at or past the last one counts as the last
        last_ch = int'(pos_ch) >= nch - 1;
        last_os = int'(pos_os) >= nos - 1;
        last_sp = int'(pos_spot) >= nsp - 1;
        last_pl = int'(pos_plane) >= npl - 1;
        ch = (int'(pos_ch) < MAX_CH) ? int'(pos_ch) : 0;

        // first oversample of a spot loads the sum, later ones add
        if (pos_os == 0)
            sum = SUM_W'(s);
        else
            sum = acc_sum[ch] + SUM_W'(s);
        acc_sum[ch] = sum;

        if (last_os)
        begin
            quotient    = {sum, {FRAC_W{1'b0}}} / DIVIDEND_W'(nos);
            res.average = quotient[AVG_W-1:0];
            res.channel = CH_OUT_W'(ch);
            res.spot    = pos_spot;
            res.plane   = pos_plane;
            res.frame   = pos_frame;
            res.done    = last_ch && last_sp && last_pl;
            averages_due.push_back(res);
            acc_sum[ch] = '0;
        end

        // advance the nested counters, channel fastest
        if (!last_ch)
            pos_ch = pos_ch + 1'b1;
        else
        begin
            pos_ch = '0;
            if (!last_os)
                pos_os = pos_os + 1'b1;
            else
            begin
                pos_os = '0;
                if (!last_sp)
                    pos_spot = pos_spot + 1'b1;
                else
                begin
                    pos_spot = '0;
                    if (!last_pl)
                        pos_plane = pos_plane + 1'b1;
                    else
                    begin
                        pos_plane = '0;
                        pos_frame = pos_frame + 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got,
                     want);
        mismatches++;
    endtask

    // Sample driver: take the next pending sample once the current one is
    // gone, and hold it steady while the block stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accumulate_sample(sample);
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (samples_to_send.size() != 0)
                begin
                    in_valid <= 1'b1;
                    sample   <= samples_to_send.pop_front();
                    // occasionally follow this item with an idle burst
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 17);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check every accepted average against the oldest
    // prediction, and throw in random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (averages_due.size() == 0)
                    report("result with nothing expected", 32'(average), 0);
                else
                begin
                    oldest_due = averages_due.pop_front();
                    if (average !== oldest_due.average)
                        report("average", 32'(average), 32'(oldest_due.average));
                    if (channel_index !== oldest_due.channel)
                        report("channel_index", 32'(channel_index),
                               32'(oldest_due.channel));
                    if (spot_index !== oldest_due.spot)
                        report("spot_index", 32'(spot_index), 32'(oldest_due.spot));
                    if (plane_index !== oldest_due.plane)
                        report("plane_index", 32'(plane_index), 32'(oldest_due.plane));
                    if (frame_index !== oldest_due.frame)
                        report("frame_index", 32'(frame_index), 32'(oldest_due.frame));
                    if (frame_done !== oldest_due.done)
                        report("frame_done", 32'(frame_done), 32'(oldest_due.done));
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 16);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send(input logic [SAMPLE_W-1:0] s);
        samples_to_send.push_back(s);
        samples_queued++;
    endtask

    // Mostly uniform samples, with full-scale and zero thrown in often
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Wait until every queued sample is taken and every average has arrived
    task automatic drain();
        while (samples_taken != samples_queued || averages_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input osa_cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (r)
            REG_CHANNEL_COUNT:    cfg_channels   = v[CH_CFG_W-1:0];
            REG_OVERSAMPLE_COUNT: cfg_oversample = v[OS_W-1:0];
            REG_SPOTS_PER_PLANE:  cfg_spots      = v[SPOT_W-1:0];
            REG_PLANE_COUNT:      cfg_planes     = v[PLANE_W-1:0];
            default:              ;
        endcase
    endtask

    // Let the block go quiet (a closing sample may still be in the divider),
    // then rewrite all four registers.
    task automatic configure(input logic [CFG_DATA_W-1:0] ch, input logic [CFG_DATA_W-1:0] os,
                             input logic [CFG_DATA_W-1:0] sp, input logic [CFG_DATA_W-1:0] pl);
        drain();
        repeat (40) @(posedge clk);
        cfg_write(REG_CHANNEL_COUNT, ch);
        cfg_write(REG_OVERSAMPLE_COUNT, os);
        cfg_write(REG_SPOTS_PER_PLANE, sp);
        cfg_write(REG_PLANE_COUNT, pl);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] os_pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every sample is a whole frame, so each one closes
        // an average with frame_done set and the frame number advancing.
        send(16'h0000);
        send(16'hFFFF);
        send(16'hAAAA);
        send(16'h5555);

        // All counts zero act as one
        configure(16'd0, 16'd0, 16'd0, 16'd0);
        send(16'h0001);
        send(16'h8000);

        // Channel count above the maximum (upper data bits ignored) clamps to
        // eight channels; walk every channel index once.
        configure(16'hFFF9, 16'd1, 16'd1, 16'd1);
        for (int i = 0; i < 8; i++)
            send(16'h1111 * i[15:0]);
        // Leave the channel counter part way through a group, then shrink
        // the group so the counter sits past its new last position.
        send(16'h0F0F);
        send(16'hF0F0);
        send(16'h7FFF);
        configure(16'd2, 16'd2, 16'd1, 16'd1);
        send(16'hFFFE);
        send(16'h0002);
        send(16'h1234);

        // Deepest sum: one channel, full oversampling, full-scale samples
        configure(16'd1, 16'd255, 16'd1, 16'd1);
        repeat (255) send(16'hFFFF);
        repeat (25) send(pick_sample());

        // Longest plane and most planes; then cut the plane short mid-way
        configure(16'd2, 16'd1, 16'd65535, 16'd255);
        repeat (60) send(pick_sample());
        configure(16'd2, 16'd1, 16'd3, 16'd255);
        repeat (40) send(pick_sample());

        // Random settings, mostly small so frames complete often
        for (int k = 0; k < 7; k++)
        begin
            case ($urandom_range(0, 5))
                0:       os_pick = 16'd0;
                1:       os_pick = CFG_DATA_W'($urandom_range(6, 40));
                default: os_pick = CFG_DATA_W'($urandom_range(1, 5));
            endcase
            configure(CFG_DATA_W'($urandom_range(0, 15)), os_pick,
                      CFG_DATA_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom_range(0, 4)));
            repeat (35) send(pick_sample());
            // hold the sender off until the block has emptied once
            if (k == 2)
                drain();
            repeat (35) send(pick_sample());
        end

        // Closing stretch with no idling on either side
        configure(16'd3, 16'd2, 16'd2, 16'd2);
        calm = 1'b1;
        repeat (60) send(pick_sample());

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("timeout with %0d averages outstanding", averages_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
